// ----- sv/lr_pkg.sv -----
// ----------------------------------------------------------------------------
// Line rasterizer package
// Coordinate widths, request codes and octant transform codes.
// ----------------------------------------------------------------------------
package lr_pkg;

	// Width of a screen coordinate (two's complement)
	localparam int COORD_BITS = 12;
	// Transformed coordinates and extents need one more bit
	localparam int CW         = COORD_BITS + 1;
	// Decision variable spans about +/- 4 * extent
	localparam int DW         = COORD_BITS + 3;

	// Request codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	// Octant transforms into (major, minor) space
	typedef enum logic [1:0] {
		OCT_IDENT    = 2'd0,
		OCT_NEG      = 2'd1,
		OCT_SWAP     = 2'd2,
		OCT_NEG_SWAP = 2'd3
	} octant_t;

endpackage

// ----- sv/line_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// Line rasterizer, all octants
// Loads two endpoints on a start request, then gives one pixel per step
// request along the line using the midpoint decision rule.
// ----------------------------------------------------------------------------
// Path: a step beat passes the request register and then the result register
//   before its pixel shows on the result ports, strobed by result_valid for one cycle.
// Throughput: one beat per clock; busy is never raised. One request register
//   and one result register around the state update set this.
// Reset: arst_n clears the line state and both strobes; no line is active.
// The receiver cannot stall: each result is valid for exactly one cycle.
module line_rasterizer_top
	import lr_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         result_valid,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         last_pixel
);

	// Request register
	logic                         valid_s1;
	logic                         req_type_s1;
	logic signed [COORD_BITS-1:0] start_x_s1, start_y_s1, end_x_s1, end_y_s1;

	// Line state
	logic                 active_q;
	octant_t              octant_q;
	logic signed [CW-1:0] major_pos_q, minor_pos_q, major_end_q;
	logic signed [CW-1:0] delta_major_q, delta_minor_q;
	logic signed [DW-1:0] decision_q;

	// Result register
	logic                         valid_s2;
	logic signed [COORD_BITS-1:0] pixel_x_s2, pixel_y_s2;
	logic                         last_s2;

	// Setup path signals
	logic signed [CW-1:0] ax0, ay0, ax1, ay1;
	logic signed [CW-1:0] lx0, ly0, lx1, ly1;
	logic signed [CW-1:0] dx, dy, neg_dx;
	octant_t              n_octant;
	logic signed [CW-1:0] n_major_pos, n_major_end, n_minor_pos, n_dmaj, n_dmin;
	logic signed [DW-1:0] n_decision;

	// Step path signals
	logic                 at_end;
	logic signed [DW-1:0] dec_adj, dec_next;
	logic signed [CW-1:0] neg_minor, neg_major;
	logic signed [CW-1:0] px_w, py_w;

	assign busy = 1'b0;

	// Capture each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_type_s1 <= req_type;
			start_x_s1  <= start_x;
			start_y_s1  <= start_y;
			end_x_s1    <= end_x;
			end_y_s1    <= end_y;
		end
	end

	// Setup: order left to right, pick octant, compute extents
	always_comb begin
		ax0 = CW'(start_x_s1);
		ay0 = CW'(start_y_s1);
		ax1 = CW'(end_x_s1);
		ay1 = CW'(end_y_s1);
		if (ax0 > ax1) begin
			lx0 = ax1; ly0 = ay1; lx1 = ax0; ly1 = ay0;
		end else begin
			lx0 = ax0; ly0 = ay0; lx1 = ax1; ly1 = ay1;
		end
		dx     = lx1 - lx0;
		dy     = ly1 - ly0;
		neg_dx = -dx;
		if (dy >= dx) begin
			n_octant    = OCT_SWAP;
			n_major_pos = ly0;
			n_major_end = ly1;
			n_minor_pos = lx0;
			n_dmaj      = dy;
			n_dmin      = dx;
		end else if (dy <= 0 && dy >= neg_dx) begin
			n_octant    = OCT_NEG;
			n_major_pos = lx0;
			n_major_end = lx1;
			n_minor_pos = -ly0;
			n_dmaj      = dx;
			n_dmin      = -dy;
		end else if (dy < neg_dx) begin
			n_octant    = OCT_NEG_SWAP;
			n_major_pos = -ly0;
			n_major_end = -ly1;
			n_minor_pos = lx0;
			n_dmaj      = -dy;
			n_dmin      = dx;
		end else begin
			n_octant    = OCT_IDENT;
			n_major_pos = lx0;
			n_major_end = lx1;
			n_minor_pos = ly0;
			n_dmaj      = dx;
			n_dmin      = dy;
		end
		n_decision = (DW'(n_dmin) <<< 1) - DW'(n_dmaj);
	end

	// Step: map back to screen space and advance the decision variable
	always_comb begin
		at_end    = major_pos_q >= major_end_q;
		neg_minor = -minor_pos_q;
		neg_major = -major_pos_q;
		case (octant_q)
			OCT_IDENT: begin
				px_w = major_pos_q; py_w = minor_pos_q;
			end
			OCT_NEG: begin
				px_w = major_pos_q; py_w = neg_minor;
			end
			OCT_SWAP: begin
				px_w = minor_pos_q; py_w = major_pos_q;
			end
			default: begin
				px_w = minor_pos_q; py_w = neg_major;
			end
		endcase
		if (decision_q >= 0) begin
			dec_adj = decision_q - (DW'(delta_major_q) <<< 1);
		end else begin
			dec_adj = decision_q;
		end
		dec_next = dec_adj + (DW'(delta_minor_q) <<< 1);
	end

	// Line state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			octant_q      <= OCT_IDENT;
			major_pos_q   <= '0;
			minor_pos_q   <= '0;
			major_end_q   <= '0;
			delta_major_q <= '0;
			delta_minor_q <= '0;
			decision_q    <= '0;
			valid_s2      <= 1'b0;
		end else begin
			valid_s2 <= 1'b0;
			if (valid_s1) begin
				if (req_type_s1 == REQ_START) begin
					active_q      <= 1'b1;
					octant_q      <= n_octant;
					major_pos_q   <= n_major_pos;
					minor_pos_q   <= n_minor_pos;
					major_end_q   <= n_major_end;
					delta_major_q <= n_dmaj;
					delta_minor_q <= n_dmin;
					decision_q    <= n_decision;
				end else if (active_q) begin
					valid_s2 <= 1'b1;
					if (at_end) begin
						active_q <= 1'b0;
					end else begin
						if (decision_q >= 0) begin
							minor_pos_q <= minor_pos_q + CW'(1);
						end
						decision_q  <= dec_next;
						major_pos_q <= major_pos_q + CW'(1);
					end
				end
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (valid_s1 && req_type_s1 == REQ_STEP && active_q) begin
			pixel_x_s2 <= px_w[COORD_BITS-1:0];
			pixel_y_s2 <= py_w[COORD_BITS-1:0];
			last_s2    <= at_end;
		end
	end

	assign result_valid = valid_s2;
	assign pixel_x      = pixel_x_s2;
	assign pixel_y      = pixel_y_s2;
	assign last_pixel   = last_s2;

	// A pixel only follows an accepted step beat, through the request and result registers
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && req_type == REQ_STEP, 2))
		else $error("result without a step request");

	// The final pixel ends the line
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_pixel |-> !active_q)
		else $error("line still active after last pixel");

	// Major position never runs past the endpoint
	a_major_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> major_pos_q <= major_end_q)
		else $error("major position beyond line end");

	// An idle block gives no pixel
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !active_q && req_type_s1 == REQ_STEP |=> !result_valid)
		else $error("pixel emitted while idle");

endmodule
